[rtl/core/dapm_pkg.sv]
// ----------------------------------------------------------------------------
// dapm_pkg
// Types, register indexes and helpers shared by the mixture priority manager.
// ----------------------------------------------------------------------------
package dapm_pkg;

	localparam int MAX_DELAY  = 50;
	localparam int HOLD_LIMIT = (MAX_DELAY < 63) ? MAX_DELAY : 63;
	localparam int HOLD_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CONC_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY  = CFG_IDX_W'(1);

	localparam logic [7:0] RELEASE_DELAY_RESET = 8'd10;

	typedef struct packed {
		logic        flex_fuel_busy;
		logic        saf_diag_req_in;
		logic        lambda_saf_active;
		logic        intrusive_cond;
		logic [15:0] canister_fuel_conc;
		logic        cpc_no_effect;
		logic        egr_no_effect;
		logic        lfbk_test_request;
		logic        afa_auth_request;
		logic        afa_learn_inhibit;
		logic        low_fuel_level;
		logic        misfire_obd_fail;
	} dapm_in_t;

	typedef struct packed {
		logic              prio_mgt_active;
		logic              saf_request_flag;
		logic              saf_diag_enable_out;
		logic              lfbk_test_enable_out;
		logic              afa_adapt_enable;
		logic              countdown_flag;
		logic [HOLD_W-1:0] delay_remaining;
	} dapm_out_t;

	// configuration as seen by the decision logic
	typedef struct packed {
		logic [15:0]       conc_threshold;
		logic [HOLD_W-1:0] reload;
	} dapm_cfg_t;

	function automatic logic [HOLD_W-1:0] clamp_hold(input logic [7:0] v);
		if (v < 8'(HOLD_LIMIT)) begin
			return v[HOLD_W-1:0];
		end
		return HOLD_W'(HOLD_LIMIT);
	endfunction

endpackage

[rtl/core/diag_adaptation_priority_manager.sv]
// ----------------------------------------------------------------------------
// diag_adaptation_priority_manager
// Fixed-priority grant of four mixture functions with a release countdown.
// ----------------------------------------------------------------------------
// One beat per task tick goes in and exactly one result beat comes out. A beat
// is taken into an input register, the grant decision is made in one pass of
// logic, and the result with the updated state lands in a result register. A
// new beat is taken every cycle while the result side keeps up. The result
// register decouples the two sides: a beat can be taken while the previous
// result still waits. Configuration writes take effect at once and are meant
// for when no beat is in flight.
module diag_adaptation_priority_manager (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  dapm_pkg::dapm_in_t                item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output dapm_pkg::dapm_out_t               result,
	input  logic                              cfg_we,
	input  logic [dapm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dapm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import dapm_pkg::*;

	dapm_cfg_t cfg;
	dapm_in_t  item_s1;
	logic      valid_s1;
	logic      advance;
	dapm_out_t next_result;
	dapm_out_t result_q;
	logic      result_valid_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	dapm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dapm_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item_s1     (item_s1),
		.cfg         (cfg),
		.next_result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/core/dapm_cfg.sv]
// ----------------------------------------------------------------------------
// dapm_cfg
// Configuration registers: concentration threshold and clamped release reload.
// ----------------------------------------------------------------------------
module dapm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dapm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dapm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output dapm_pkg::dapm_cfg_t               cfg
);
	import dapm_pkg::*;

	logic [15:0] conc_threshold_q;
	logic [7:0]  release_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conc_threshold_q <= '0;
			release_delay_q  <= RELEASE_DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONC_THRESHOLD: conc_threshold_q <= cfg_wdata[15:0];
				CFG_RELEASE_DELAY:  release_delay_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.conc_threshold = conc_threshold_q;
	assign cfg.reload         = clamp_hold(release_delay_q);

endmodule

[rtl/core/dapm_decide.sv]
// ----------------------------------------------------------------------------
// dapm_decide
// Grant state and fixed-priority decision for one tick.
// ----------------------------------------------------------------------------
module dapm_decide (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  dapm_pkg::dapm_in_t   item_s1,
	input  dapm_pkg::dapm_cfg_t  cfg,
	output dapm_pkg::dapm_out_t  next_result
);
	import dapm_pkg::*;

	dapm_out_t st_q;
	dapm_out_t nxt;
	logic      qualify;

	assign qualify = item_s1.intrusive_cond
		&& (item_s1.canister_fuel_conc <= cfg.conc_threshold)
		&& !st_q.lfbk_test_enable_out && !st_q.saf_diag_enable_out
		&& !st_q.afa_adapt_enable && !st_q.saf_request_flag;

	always_comb begin
		nxt = st_q;
		if (st_q.countdown_flag) begin
			if (st_q.delay_remaining != '0) begin
				nxt.delay_remaining = clamp_hold(8'(st_q.delay_remaining - HOLD_W'(1)));
			end else begin
				nxt.countdown_flag  = 1'b0;
				nxt.prio_mgt_active = 1'b0;
				nxt.delay_remaining = cfg.reload;
			end
		end else if (qualify) begin
			nxt.prio_mgt_active = 1'b1;
		end else if (st_q.prio_mgt_active) begin
			// release starts once the intrusive conditions drop
			if (!item_s1.intrusive_cond) begin
				nxt.countdown_flag = 1'b1;
			end
		end else if (item_s1.saf_diag_req_in) begin
			nxt.saf_request_flag     = 1'b1;
			nxt.afa_adapt_enable     = 1'b0;
			nxt.lfbk_test_enable_out = 1'b0;
			nxt.saf_diag_enable_out  = item_s1.lambda_saf_active && item_s1.cpc_no_effect
				&& item_s1.egr_no_effect && !item_s1.flex_fuel_busy;
		end else begin
			nxt.saf_request_flag    = 1'b0;
			nxt.saf_diag_enable_out = 1'b0;
			if (item_s1.lfbk_test_request) begin
				nxt.afa_adapt_enable     = 1'b0;
				nxt.lfbk_test_enable_out = item_s1.cpc_no_effect && item_s1.egr_no_effect
					&& !item_s1.flex_fuel_busy;
			end else begin
				nxt.lfbk_test_enable_out = 1'b0;
				nxt.afa_adapt_enable = item_s1.afa_auth_request && !item_s1.afa_learn_inhibit
					&& item_s1.cpc_no_effect && !item_s1.flex_fuel_busy
					&& !item_s1.low_fuel_level && !item_s1.misfire_obd_fail;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	assign next_result = nxt;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mixture-function priority manager. A queue of
// task ticks feeds a valid/ready driver; each accepted tick runs through an
// in-bench model of the grant logic and release countdown, and every result
// beat is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;

	import dapm_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_TICKS = 250;

	// indexes with no register behind them, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	dapm_in_t              item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	dapm_out_t             result;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

	dapm_in_t    ticks_pending[$];
	dapm_out_t   grant_results_due[$];
	int unsigned ticks_sent    = 0;
	int unsigned ticks_taken   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_cycles  = 0;
	int unsigned mismatches    = 0;

	// bench copy of the registers and the grant state
	logic [15:0]       conc_limit = 16'd0;
	logic [7:0]        reload_reg = RELEASE_DELAY_RESET;
	logic              cd_running = 1'b0;
	logic [HOLD_W-1:0] hold_ticks = '0;
	logic              prio       = 1'b0;
	logic              saf_req_q  = 1'b0;
	logic              saf_en     = 1'b0;
	logic              lfbk_en    = 1'b0;
	logic              afa_en     = 1'b0;

	diag_adaptation_priority_manager dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic logic [HOLD_W-1:0] to_hold(input int unsigned v);
		return (v < HOLD_LIMIT) ? HOLD_W'(v) : HOLD_W'(HOLD_LIMIT);
	endfunction

	// one task tick: update the grant state and return what the block shows
	function automatic dapm_out_t mix_grant_tick(input dapm_in_t t);
		dapm_out_t r;
		if (cd_running) begin
			if (hold_ticks != 0) begin
				hold_ticks = to_hold(32'(hold_ticks) - 1);
			end else begin
				cd_running = 1'b0;
				prio       = 1'b0;
				hold_ticks = to_hold(32'(reload_reg));
			end
		end else if (t.intrusive_cond && t.canister_fuel_conc <= conc_limit && !lfbk_en
				&& !saf_en && !afa_en && !saf_req_q) begin
			prio = 1'b1;
		end else if (prio) begin
			if (!t.intrusive_cond) begin
				cd_running = 1'b1;
			end
		end else if (t.saf_diag_req_in) begin
			saf_req_q = 1'b1;
			afa_en    = 1'b0;
			lfbk_en   = 1'b0;
			saf_en    = t.lambda_saf_active && t.cpc_no_effect && t.egr_no_effect
				&& !t.flex_fuel_busy;
		end else begin
			saf_req_q = 1'b0;
			saf_en    = 1'b0;
			if (t.lfbk_test_request) begin
				afa_en  = 1'b0;
				lfbk_en = t.cpc_no_effect && t.egr_no_effect && !t.flex_fuel_busy;
			end else begin
				lfbk_en = 1'b0;
				afa_en  = t.afa_auth_request && !t.afa_learn_inhibit && t.cpc_no_effect
					&& !t.flex_fuel_busy && !t.low_fuel_level && !t.misfire_obd_fail;
			end
		end
		r.prio_mgt_active      = prio;
		r.saf_request_flag     = saf_req_q;
		r.saf_diag_enable_out  = saf_en;
		r.lfbk_test_enable_out = lfbk_en;
		r.afa_adapt_enable     = afa_en;
		r.countdown_flag       = cd_running;
		r.delay_remaining      = hold_ticks;
		return r;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	// driver: a new beat only once the previous one has been taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (ticks_taken == ticks_sent) begin
				if (ticks_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					item       <= ticks_pending.pop_front();
					item_valid <= 1'b1;
					ticks_sent <= ticks_sent + 1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		dapm_out_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (grant_results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result beat, expected none, actual %h", $time, result);
				end else begin
					want = grant_results_due.pop_front();
					check_field("prio_mgt_active", 32'(want.prio_mgt_active),
						32'(result.prio_mgt_active));
					check_field("saf_request_flag", 32'(want.saf_request_flag),
						32'(result.saf_request_flag));
					check_field("saf_diag_enable_out", 32'(want.saf_diag_enable_out),
						32'(result.saf_diag_enable_out));
					check_field("lfbk_test_enable_out", 32'(want.lfbk_test_enable_out),
						32'(result.lfbk_test_enable_out));
					check_field("afa_adapt_enable", 32'(want.afa_adapt_enable),
						32'(result.afa_adapt_enable));
					check_field("countdown_flag", 32'(want.countdown_flag),
						32'(result.countdown_flag));
					check_field("delay_remaining", 32'(want.delay_remaining),
						32'(result.delay_remaining));
				end
			end
			if (item_valid && item_ready) begin
				grant_results_due.push_back(mix_grant_tick(item));
				ticks_taken++;
			end
			if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CFG_CONC_THRESHOLD) begin
			conc_limit = val;
		end else if (idx == CFG_RELEASE_DELAY) begin
			reload_reg = val[7:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// counters settle at the rising edge, so the drained state is judged there
	task automatic wait_drained();
		while (!(ticks_pending.size() == 0 && ticks_taken == ticks_sent
				&& grant_results_due.size() == 0)) begin
			@(posedge clk);
		end
	endtask

	function automatic dapm_in_t rand_tick();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(dapm_in_t)-1:0];
	endfunction

	function automatic logic [15:0] conc_below();
		return 16'($urandom_range(conc_limit, 0));
	endfunction

	function automatic logic [15:0] conc_above();
		if (conc_limit == 16'hFFFF) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(16'hFFFF, conc_limit + 1));
	endfunction

	// mostly full grant/release cycles with random content, some plain noise
	task automatic queue_phase(input int unsigned n_live);
		dapm_in_t    t;
		int unsigned live;
		int unsigned k;
		int unsigned span;
		live = 0;
		while (live < n_live) begin
			if ($urandom_range(9, 0) < 7) begin
				// drop every request so the other grants fall away
				span = $urandom_range(2, 1);
				for (k = 0; k < span; k++) begin
					t = rand_tick();
					t.intrusive_cond    = 1'b0;
					t.saf_diag_req_in   = 1'b0;
					t.lfbk_test_request = 1'b0;
					t.afa_auth_request  = 1'b0;
					ticks_pending.push_back(t);
				end
				t = rand_tick();
				t.intrusive_cond     = 1'b1;
				t.canister_fuel_conc = conc_below();
				ticks_pending.push_back(t);
				// priority held while conditions persist
				span = $urandom_range(3, 0);
				for (k = 0; k < span; k++) begin
					t = rand_tick();
					t.intrusive_cond     = 1'b1;
					t.canister_fuel_conc = conc_above();
					ticks_pending.push_back(t);
				end
				live += span + 4;
				t = rand_tick();
				t.intrusive_cond = 1'b0;
				ticks_pending.push_back(t);
				// ride out the countdown, content is ignored here
				span = ((reload_reg < HOLD_LIMIT) ? reload_reg : HOLD_LIMIT)
					+ $urandom_range(3, 1);
				for (k = 0; k < span; k++) begin
					ticks_pending.push_back(rand_tick());
				end
				live += span;
			end else begin
				span = $urandom_range(6, 1);
				for (k = 0; k < span; k++) begin
					ticks_pending.push_back(rand_tick());
				end
				live += span;
			end
		end
	endtask

	task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
			input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] rel);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		write_reg(CFG_CONC_THRESHOLD, thr);
		write_reg(CFG_RELEASE_DELAY, rel);
		queue_phase(PHASE_TICKS);
		wait_drained();
	endtask

	initial begin
		dapm_in_t t;
		int unsigned k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed ticks on reset register values
		ticks_pending.push_back('0);
		t = '0;
		t.intrusive_cond = 1'b1;
		ticks_pending.push_back(t);                 // grant
		t.canister_fuel_conc = 16'hFFFF;
		ticks_pending.push_back(t);                 // held, nothing changes
		ticks_pending.push_back('0);                // release from a zero countdown
		ticks_pending.push_back('0);                // expiry on the next tick
		t = '0;
		t.saf_diag_req_in   = 1'b1;
		t.lambda_saf_active = 1'b1;
		t.cpc_no_effect     = 1'b1;
		t.egr_no_effect     = 1'b1;
		ticks_pending.push_back(t);
		t.flex_fuel_busy = 1'b1;
		ticks_pending.push_back(t);
		t = '0;
		t.lfbk_test_request = 1'b1;
		t.cpc_no_effect     = 1'b1;
		t.egr_no_effect     = 1'b1;
		ticks_pending.push_back(t);
		t.egr_no_effect = 1'b0;
		ticks_pending.push_back(t);
		t = '0;
		t.afa_auth_request = 1'b1;
		t.cpc_no_effect    = 1'b1;
		ticks_pending.push_back(t);
		t.intrusive_cond    = 1'b1;                 // blocked by the adaptation grant
		t.afa_learn_inhibit = 1'b1;
		ticks_pending.push_back(t);
		t.intrusive_cond    = 1'b0;
		t.afa_learn_inhibit = 1'b0;
		t.low_fuel_level    = 1'b1;
		ticks_pending.push_back(t);
		t.low_fuel_level   = 1'b0;
		t.misfire_obd_fail = 1'b1;
		ticks_pending.push_back(t);
		t = '0;
		t.intrusive_cond = 1'b1;
		ticks_pending.push_back(t);
		ticks_pending.push_back('0);                // countdown from the reload
		for (k = 0; k < 3; k++) begin
			ticks_pending.push_back('1);            // all fields high, ignored
		end
		wait_drained();

		run_phase(14, 76, 16'hFFFF, 16'h00FF);      // reload clamps to the limit
		run_phase(14, 76, 16'h0000, 16'hAB00);      // upper data bits dropped, reload 0
		write_reg(CFG_UNUSED_LO, 16'($urandom));
		write_reg(CFG_UNUSED_HI, 16'($urandom));
		run_phase(76, 14, 16'($urandom), 16'(MAX_DELAY));
		run_phase(76, 14, 16'($urandom), 16'(MAX_DELAY + 1));
		run_phase(0, 0, 16'h00FF, 16'h0001);
		run_phase(0, 0, 16'($urandom), 16'($urandom_range(63, 0)));

		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
